[rtl/midi_sysex_pacing_buffer_defines.svh]
// assertion macros for the midi sysex pacing buffer
// used by the top level, expects clk and rst_n in scope
`ifndef MIDI_SYSEX_PACING_BUFFER_DEFINES_SVH
`define MIDI_SYSEX_PACING_BUFFER_DEFINES_SVH

// same-cycle implication
`define MSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msp assertion failed");

// next-cycle implication
`define MSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msp assertion failed");

`endif

[rtl/msp_pkg.sv]
// shared types and constants of the midi sysex pacing buffer
// no dependencies
package msp_pkg;

    localparam int LEN_W  = 7;
    localparam int DLY_W  = 24;
    localparam int DPB_W  = 16;
    localparam int FRAC_W = 8;
    localparam int SC_W   = 16;

    localparam logic [1:0] CMD_HOST   = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_DEVICE = 2'd2;

    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    localparam logic [DPB_W-1:0] DELAY_RESET = 16'd2258;

    localparam logic ARITH_CMP = 1'b0;
    localparam logic ARITH_MUL = 1'b1;

    typedef struct packed {
        logic [1:0]      command;
        logic [7:0]      data_byte;
        logic [SC_W-1:0] sample_count;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic             byte_we;
        logic             len_we;
        logic [7:0]       byte_data;
        logic [LEN_W-1:0] len_data;
    } st_wr_t;

endpackage

[rtl/msp_arith.sv]
// shared arithmetic unit: compare with absolute difference, or length times rate
// depends on msp_pkg
module msp_arith (
    input  logic                     op,
    input  logic [msp_pkg::DLY_W-1:0] a,
    input  logic [msp_pkg::DLY_W-1:0] b,
    output logic [msp_pkg::DLY_W-1:0] res,
    output logic                     ge
);
    import msp_pkg::*;

    logic [DLY_W-1:0]       diff;
    logic [LEN_W+DPB_W-1:0] prod;

    assign ge   = (a >= b);
    assign diff = ge ? (a - b) : (b - a);
    assign prod = a[LEN_W-1:0] * b[DPB_W-1:0];

    always_comb
    begin
        case (op)
            ARITH_MUL: res = DLY_W'(prod[LEN_W+DPB_W-1:FRAC_W]);
            default:   res = diff;
        endcase
    end

endmodule

[rtl/msp_store.sv]
// byte store and message length memories with registered reads
// depends on msp_pkg
module msp_store #(
    parameter int BYTE_DEPTH    = 64,
    parameter int MESSAGE_DEPTH = 32,
    localparam int BW = $clog2(BYTE_DEPTH),
    localparam int MW = $clog2(MESSAGE_DEPTH)
) (
    input  logic                      clk,
    input  msp_pkg::st_wr_t           wr,
    input  logic [BW-1:0]             byte_waddr,
    input  logic [MW-1:0]             len_waddr,
    input  logic [BW-1:0]             byte_raddr,
    input  logic [MW-1:0]             len_raddr,
    output logic [7:0]                byte_rdata,
    output logic [msp_pkg::LEN_W-1:0] len_rdata
);
    import msp_pkg::*;

    logic [7:0]       byte_mem [BYTE_DEPTH];
    logic [LEN_W-1:0] len_mem  [MESSAGE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.byte_we)
        begin
            byte_mem[byte_waddr] <= wr.byte_data;
        end
        byte_rdata <= byte_mem[byte_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.len_we)
        begin
            len_mem[len_waddr] <= wr.len_data;
        end
        len_rdata <= len_mem[len_raddr];
    end

endmodule

[rtl/msp_ctrl.sv]
// sequencer: host byte collection, tick pacing and release, device byte pass-through
// depends on msp_pkg, msp_arith, msp_store
module msp_ctrl #(
    parameter int BYTE_DEPTH    = 64,
    parameter int MESSAGE_DEPTH = 32,
    localparam int CW = $clog2(BYTE_DEPTH + 1),
    localparam int QW = $clog2(MESSAGE_DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  msp_pkg::in_beat_t         req,
    input  logic [msp_pkg::DPB_W-1:0] delay_per_byte,
    output logic                      busy,
    output logic                      emit_valid,
    output msp_pkg::out_beat_t        emit_beat,
    input  logic                      emit_ready,
    output logic [CW-1:0]             stored_cnt,
    output logic [QW-1:0]             queued_cnt
);
    import msp_pkg::*;

    localparam int BW = $clog2(BYTE_DEPTH);
    localparam int MW = $clog2(MESSAGE_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_EMIT   = 4'd2;
    localparam logic [3:0] S_TSUB   = 4'd3;
    localparam logic [3:0] S_TLEN   = 4'd4;
    localparam logic [3:0] S_TMUL   = 4'd5;
    localparam logic [3:0] S_TCMP   = 4'd6;
    localparam logic [3:0] S_TBYTE  = 4'd7;
    localparam logic [3:0] S_TOUT   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       cmd_reg;
    logic [7:0]       byte_reg;
    logic [SC_W-1:0]  rem_reg, rem_next;
    logic [DLY_W-1:0] dly_reg, dly_next;
    logic [DLY_W-1:0] dnew_reg, dnew_next;
    logic             end_reg, end_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [BW-1:0]    shead_reg, shead_next;
    logic [BW-1:0]    tail_reg, tail_next;
    logic [MW-1:0]    lhead_reg, lhead_next;
    logic [CW-1:0]    stored_reg, stored_next;
    logic [QW-1:0]    queued_reg, queued_next;
    logic [CW-1:0]    clen_reg, clen_next;
    logic             coll_reg, coll_next;
    logic             disc_reg, disc_next;
    logic             dev_reg, dev_next;
    out_beat_t        emit_reg, emit_next;

    logic             ar_op;
    logic [DLY_W-1:0] ar_a, ar_b, ar_res;
    logic             ar_ge;

    st_wr_t           st_wr;
    logic [BW-1:0]    byte_waddr;
    logic [MW-1:0]    len_waddr;
    logic [7:0]       byte_rdata;
    logic [LEN_W-1:0] len_rdata;

    // host side address math
    logic             coll_now;
    logic [CW:0]      fill_sum;
    logic [BW:0]      idx_sum, idx_wrap;
    logic [BW:0]      tail_sum, tail_wrap;
    logic [MW:0]      slot_sum, slot_wrap;

    msp_arith u_arith (
        .op  (ar_op),
        .a   (ar_a),
        .b   (ar_b),
        .res (ar_res),
        .ge  (ar_ge)
    );

    msp_store #(
        .BYTE_DEPTH    (BYTE_DEPTH),
        .MESSAGE_DEPTH (MESSAGE_DEPTH)
    ) u_store (
        .clk        (clk),
        .wr         (st_wr),
        .byte_waddr (byte_waddr),
        .len_waddr  (len_waddr),
        .byte_raddr (shead_reg),
        .len_raddr  (lhead_reg),
        .byte_rdata (byte_rdata),
        .len_rdata  (len_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign stored_cnt = stored_reg;
    assign queued_cnt = queued_reg;

    assign coll_now  = coll_reg | (byte_reg == SYSEX_START);
    assign fill_sum  = {1'b0, stored_reg} + {1'b0, clen_reg};
    assign idx_sum   = {1'b0, tail_reg} + (BW+1)'(clen_reg);
    assign idx_wrap  = (idx_sum >= (BW+1)'(BYTE_DEPTH)) ? idx_sum - (BW+1)'(BYTE_DEPTH) : idx_sum;
    // new tail sits one past the end byte of the message
    assign tail_sum  = idx_wrap + (BW+1)'(1);
    assign tail_wrap = (tail_sum >= (BW+1)'(BYTE_DEPTH)) ?
                       tail_sum - (BW+1)'(BYTE_DEPTH) : tail_sum;
    assign slot_sum  = {1'b0, lhead_reg} + (MW+1)'(queued_reg);
    assign slot_wrap = (slot_sum >= (MW+1)'(MESSAGE_DEPTH)) ?
                       slot_sum - (MW+1)'(MESSAGE_DEPTH) : slot_sum;

    assign byte_waddr = idx_wrap[BW-1:0];
    assign len_waddr  = slot_wrap[MW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        dly_next    = dly_reg;
        dnew_next   = dnew_reg;
        end_next    = end_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        shead_next  = shead_reg;
        tail_next   = tail_reg;
        lhead_next  = lhead_reg;
        stored_next = stored_reg;
        queued_next = queued_reg;
        clen_next   = clen_reg;
        coll_next   = coll_reg;
        disc_next   = disc_reg;
        dev_next    = dev_reg;
        emit_next   = emit_reg;
        emit_valid  = 1'b0;
        emit_beat   = emit_reg;
        ar_op       = ARITH_CMP;
        ar_a        = DLY_W'(rem_reg);
        ar_b        = dly_reg;
        st_wr       = '{byte_we: 1'b0, len_we: 1'b0, byte_data: byte_reg,
                        len_data: LEN_W'(clen_next)};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (cmd_reg)
                    CMD_HOST:
                    begin
                        coll_next = coll_now;
                        if (coll_now)
                        begin
                            if (!disc_reg)
                            begin
                                if (fill_sum >= (CW+1)'(BYTE_DEPTH))
                                begin
                                    disc_next  = 1'b1;
                                    clen_next  = '0;
                                    emit_next  = '{KIND_DROP, 8'h00, 1'b1};
                                    state_next = S_EMIT;
                                end
                                else
                                begin
                                    st_wr.byte_we = 1'b1;
                                    clen_next     = clen_reg + 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            emit_next  = '{KIND_RX, byte_reg, 1'b1};
                            state_next = S_EMIT;
                        end
                        if (byte_reg == SYSEX_END)
                        begin
                            if (coll_now && !disc_next && clen_next != '0)
                            begin
                                if (queued_reg >= QW'(MESSAGE_DEPTH))
                                begin
                                    emit_next  = '{KIND_DROP, 8'h00, 1'b1};
                                    state_next = S_EMIT;
                                end
                                else
                                begin
                                    st_wr.len_we   = 1'b1;
                                    st_wr.len_data = LEN_W'(clen_next);
                                    queued_next    = queued_reg + 1'b1;
                                    stored_next    = stored_reg + clen_next;
                                    tail_next      = tail_wrap[BW-1:0];
                                end
                            end
                            coll_next = 1'b0;
                            disc_next = 1'b0;
                            clen_next = '0;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (!dev_reg)
                        begin
                            state_next = S_TSUB;
                        end
                    end
                    CMD_DEVICE:
                    begin
                        if (byte_reg == SYSEX_START)
                        begin
                            dev_next = 1'b1;
                        end
                        else if (byte_reg == SYSEX_END)
                        begin
                            dev_next = 1'b0;
                        end
                        emit_next  = '{KIND_HOST, byte_reg, 1'b1};
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                emit_valid = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            // count the pacing delay down against the samples left
            S_TSUB:
            begin
                if (queued_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (ar_ge)
                begin
                    rem_next   = ar_res[SC_W-1:0];
                    dly_next   = '0;
                    state_next = S_TLEN;
                end
                else
                begin
                    dly_next   = ar_res;
                    rem_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_TLEN:
            begin
                len_next   = len_rdata;
                cnt_next   = len_rdata;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                ar_op      = ARITH_MUL;
                ar_a       = DLY_W'(len_reg);
                ar_b       = DLY_W'(delay_per_byte);
                dnew_next  = ar_res;
                state_next = S_TCMP;
            end
            // the run ends after this message if it is the last or its delay outlasts the tick
            S_TCMP:
            begin
                ar_b       = dnew_reg;
                end_next   = (queued_reg == QW'(1)) || !ar_ge;
                state_next = S_TBYTE;
            end
            S_TBYTE:
            begin
                state_next = S_TOUT;
            end
            S_TOUT:
            begin
                emit_valid = 1'b1;
                emit_beat  = '{KIND_RX, byte_rdata, (cnt_reg == LEN_W'(1)) && end_reg};
                if (emit_ready)
                begin
                    shead_next = (shead_reg == BW'(BYTE_DEPTH - 1)) ? '0 : shead_reg + 1'b1;
                    if (cnt_reg == LEN_W'(1))
                    begin
                        dly_next    = dnew_reg;
                        lhead_next  = (lhead_reg == MW'(MESSAGE_DEPTH - 1)) ?
                                      '0 : lhead_reg + 1'b1;
                        queued_next = queued_reg - 1'b1;
                        stored_next = stored_reg - CW'(len_reg);
                        state_next  = S_TSUB;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_TBYTE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dly_reg    <= '0;
            shead_reg  <= '0;
            tail_reg   <= '0;
            lhead_reg  <= '0;
            stored_reg <= '0;
            queued_reg <= '0;
            clen_reg   <= '0;
            coll_reg   <= 1'b0;
            disc_reg   <= 1'b0;
            dev_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            dly_reg    <= dly_next;
            shead_reg  <= shead_next;
            tail_reg   <= tail_next;
            lhead_reg  <= lhead_next;
            stored_reg <= stored_next;
            queued_reg <= queued_next;
            clen_reg   <= clen_next;
            coll_reg   <= coll_next;
            disc_reg   <= disc_next;
            dev_reg    <= dev_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.command;
            byte_reg <= req.data_byte;
            rem_reg  <= req.sample_count;
        end
        else
        begin
            rem_reg <= rem_next;
        end
        dnew_reg <= dnew_next;
        end_reg  <= end_next;
        len_reg  <= len_next;
        emit_reg <= emit_next;
    end

endmodule

[rtl/midi_sysex_pacing_buffer.sv]
// midi sysex pacing buffer: routes host midi bytes, queues sysex and paces its release
// depends on msp_pkg, msp_ctrl and midi_sysex_pacing_buffer_defines.svh
//
// request channel (req_valid, req_stall, req_beat) carries one command per beat:
// a host midi byte, a sample tick, or a device transmit byte. result channel
// (rsp_valid, rsp_stall, rsp_beat) returns bytes to the receiver, bytes to the
// host and drop notices; last_of_run marks the final result of a request.
// a request is taken only while the sequencer is idle. a host or device byte
// is decoded, then emits its result if it has one. a tick releases nothing while
// the device sends sysex; else each released message steps through a subtract, a
// length read, a multiply and a compare, and each released byte through a store
// read and an output, paced by the byte store read port and the shared compare and
// multiply unit. a result appears in the output register the cycle after it is produced,
// and the sequencer waits while that register is full and rsp_stall is high, so nothing is lost.
// cfg_we writes delay_per_byte; write it only while idle.
// reset clears pointers, counters, flags and the pacing delay and loads the
// default delay_per_byte; the stores need no clearing pass.
`include "midi_sysex_pacing_buffer_defines.svh"

module midi_sysex_pacing_buffer #(
    parameter int BYTE_DEPTH    = 64,
    parameter int MESSAGE_DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  msp_pkg::in_beat_t         req_beat,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output msp_pkg::out_beat_t        rsp_beat,
    input  logic                      cfg_we,
    input  logic [msp_pkg::DPB_W-1:0] cfg_wdata
);
    import msp_pkg::*;

    localparam int CW = $clog2(BYTE_DEPTH + 1);
    localparam int QW = $clog2(MESSAGE_DEPTH + 1);

    logic             busy;
    logic             accept;
    logic             emit_valid;
    logic             emit_ready;
    out_beat_t        emit_beat;
    logic [DPB_W-1:0] dpb_reg;
    logic             rsp_valid_reg;
    out_beat_t        rsp_beat_reg;
    logic [CW-1:0]    stored_cnt;
    logic [QW-1:0]    queued_cnt;

    assign req_stall  = busy;
    assign accept     = req_valid && !busy;
    assign emit_ready = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_beat   = rsp_beat_reg;

    msp_ctrl #(
        .BYTE_DEPTH    (BYTE_DEPTH),
        .MESSAGE_DEPTH (MESSAGE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req            (req_beat),
        .delay_per_byte (dpb_reg),
        .busy           (busy),
        .emit_valid     (emit_valid),
        .emit_beat      (emit_beat),
        .emit_ready     (emit_ready),
        .stored_cnt     (stored_cnt),
        .queued_cnt     (queued_cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpb_reg <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            dpb_reg <= cfg_wdata;
        end
    end

    // output register between sequencer and receiver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit_valid && emit_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
        begin
            rsp_beat_reg <= emit_beat;
        end
    end

    `MSP_ASSERT_NEXT(a_accept_busy, accept, req_stall)
    `MSP_ASSERT_NOW(a_stored_bound, 1'b1, stored_cnt <= CW'(BYTE_DEPTH))
    `MSP_ASSERT_NOW(a_queued_bound, 1'b1, queued_cnt <= QW'(MESSAGE_DEPTH))
    `MSP_ASSERT_NOW(a_empty_queue, queued_cnt == '0, stored_cnt == '0)

endmodule
